// File: hw/rtl/mvic_pkg.sv
`timescale 1ns / 1ps

package mvic_pkg;

  localparam int unsigned MAX_VERTICES = 65536;
  localparam int unsigned VTX_AW       = $clog2(MAX_VERTICES);
  localparam int unsigned CNT_W        = 17;
  localparam int unsigned SLOT_W       = 17;
  localparam int unsigned COMPACT_W    = 16;
  localparam int unsigned SRC_W        = 16;
  localparam int unsigned CORNER_W     = 32;
  localparam int unsigned EPOCH_W      = 8;

  localparam logic [CNT_W-1:0]   MAX_COUNT = CNT_W'(MAX_VERTICES);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = {EPOCH_W{1'b1}};

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_EV   = 3'd4;

  localparam logic [1:0] LAST_CORNER = 2'd2;

  typedef struct packed {
    logic [EPOCH_W-1:0]   epoch;
    logic [COMPACT_W-1:0] slot;
  } mvic_entry_t;

endpackage

// File: hw/rtl/mesh_vertex_index_compactor.sv
`timescale 1ns / 1ps

// output: a triangle's words follow its corner checks; each word takes a remap read
// step, then an update step, set by the single remap memory port; the update step
// waits while the output is held; a new triangle is taken only in idle, once the
// last one ends; corner checks share one compare unit, 1 corner a cycle
// reset: a clearing pass sweeps all MAX_VERTICES entries of the remap memory, and one
// more pass runs on every 255th new_mesh when the epoch mark wraps
module mesh_vertex_index_compactor (
  input  logic                clk_i,
  input  logic                rst_ni,
  // slave stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [95:0]         s_axis_tdata,   // corner_a, corner_b, corner_c
  input  logic                s_axis_tuser,   // new_mesh
  // master stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,   // compact_index, source_index
  output logic                m_axis_tuser,   // first_use
  output logic                m_axis_tlast,   // last_corner
  // apb
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mvic_pkg::*;

  logic [2:0]              state_q, state_d;
  logic [1:0]              k_q, k_d;
  logic [VTX_AW-1:0]       clr_cnt_q, clr_cnt_d;
  logic                    clr_resume_q, clr_resume_d;
  logic [EPOCH_W-1:0]      epoch_q, epoch_d;
  logic [SLOT_W-1:0]       next_slot_q, next_slot_d;
  logic [CNT_W-1:0]        vcount_q;
  logic [CORNER_W-1:0]     corner_q [3];
  logic                    out_valid_q, out_valid_d;
  logic [COMPACT_W-1:0]    out_compact_q;
  logic [SRC_W-1:0]        out_source_q;
  logic                    out_first_q;
  logic                    out_last_q;
  logic                    load_out;

  mvic_entry_t             mem_q [MAX_VERTICES];
  mvic_entry_t             rdata_q;
  mvic_entry_t             wdata;
  logic [VTX_AW-1:0]       mem_addr;
  logic                    mem_we;
  logic                    mem_re;

  logic                    in_acc;
  logic                    cfg_wr;
  logic [CNT_W-1:0]        eff_cnt;
  logic [CORNER_W-1:0]     corner_sel;
  logic                    corner_ok;
  logic                    hit;
  logic                    out_free;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : 32'(vcount_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q <= '0;
    end else if (cfg_wr) begin
      vcount_q <= pwdata[CNT_W-1:0];
    end
  end

  // shared compare unit for corner range checks
  assign eff_cnt    = (vcount_q > MAX_COUNT) ? MAX_COUNT : vcount_q;
  assign corner_sel = corner_q[k_q];
  assign corner_ok  = !corner_sel[CORNER_W-1] &&
                      (corner_sel[CORNER_W-2:0] < (CORNER_W-1)'(eff_cnt));

  assign hit      = (rdata_q.epoch == epoch_q);
  assign out_free = !out_valid_q || m_axis_tready;
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d      = state_q;
    k_d          = k_q;
    clr_cnt_d    = clr_cnt_q;
    clr_resume_d = clr_resume_q;
    epoch_d      = epoch_q;
    next_slot_d  = next_slot_q;
    out_valid_d  = out_valid_q;
    load_out     = 1'b0;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_addr     = corner_sel[VTX_AW-1:0];
    wdata.epoch  = epoch_q;
    wdata.slot   = next_slot_q[COMPACT_W-1:0];

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_cnt_q;
        wdata     = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (&clr_cnt_q) begin
          state_d = clr_resume_q ? ST_CHK : ST_IDLE;
        end
      end
      ST_IDLE: begin
        k_d = '0;
        if (in_acc) begin
          state_d = ST_CHK;
          if (s_axis_tuser) begin
            next_slot_d = '0;
            if (epoch_q == EPOCH_MAX) begin
              epoch_d      = EPOCH_W'(1);
              clr_resume_d = 1'b1;
              clr_cnt_d    = '0;
              state_d      = ST_CLR;
            end else begin
              epoch_d = epoch_q + 1'b1;
            end
          end
        end
      end
      ST_CHK: begin
        if (!corner_ok) begin
          state_d = ST_IDLE;
        end else if (k_q == LAST_CORNER) begin
          k_d     = '0;
          state_d = ST_RD;
        end else begin
          k_d = k_q + 1'b1;
        end
      end
      ST_RD: begin
        mem_re  = 1'b1;
        state_d = ST_EV;
      end
      ST_EV: begin
        if (out_free) begin
          load_out    = 1'b1;
          out_valid_d = 1'b1;
          if (!hit) begin
            mem_we      = 1'b1;
            next_slot_d = next_slot_q + 1'b1;
          end
          if (k_q == LAST_CORNER) begin
            state_d = ST_IDLE;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLR;
      k_q          <= '0;
      clr_cnt_q    <= '0;
      clr_resume_q <= 1'b0;
      epoch_q      <= EPOCH_W'(1);
      next_slot_q  <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      k_q          <= k_d;
      clr_cnt_q    <= clr_cnt_d;
      clr_resume_q <= (state_q == ST_CLR && state_d != ST_CLR) ? 1'b0 : clr_resume_d;
      epoch_q      <= epoch_d;
      next_slot_q  <= next_slot_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      corner_q[0] <= s_axis_tdata[31:0];
      corner_q[1] <= s_axis_tdata[63:32];
      corner_q[2] <= s_axis_tdata[95:64];
    end
    if (load_out) begin
      out_compact_q <= hit ? rdata_q.slot : next_slot_q[COMPACT_W-1:0];
      out_source_q  <= corner_sel[SRC_W-1:0];
      out_first_q   <= !hit;
      out_last_q    <= (k_q == LAST_CORNER);
    end
  end

  // remap memory, one port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= wdata;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_addr];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_source_q, out_compact_q};
  assign m_axis_tuser  = out_first_q;
  assign m_axis_tlast  = out_last_q;

  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (state_q == ST_CLR || state_q == ST_EV))
    else $error("remap write outside clear or update");

  a_epoch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != '0)
    else $error("epoch mark is zero");

  a_out_from_ev: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == ST_EV)
    else $error("output word without update step");

  a_clr_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLR) |-> !s_axis_tready)
    else $error("input taken during clearing pass");

endmodule
